### design/caged_gyro_zero_offset_calibrator_unit_defines.svh
// Assertion macros used by the calibrator top-level RTL.
`ifndef CAGED_GYRO_ZERO_OFFSET_CALIBRATOR_UNIT_DEFINES_SVH
`define CAGED_GYRO_ZERO_OFFSET_CALIBRATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CGZO_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("calibrator same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CGZO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("calibrator next-cycle check failed");

`endif

### design/cgzo_pkg.sv
`default_nettype none
package cgzo_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned CODE_IN_W = 12;
  localparam int unsigned CORR_W  = 12;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned DEV_W   = 31;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEVIATION = 2'd2;

  localparam logic [CNT_W-1:0]  SAMPLE_COUNT_RST  = 16'd1024;
  localparam logic [TIME_W-1:0] WAIT_INTERVAL_RST = 32'd5000;
  localparam logic [DEV_W-1:0]  MAX_DEVIATION_RST = 31'd100;

  localparam logic [TIME_W-1:0] SETTLE_TIME    = 32'd500;
  localparam logic [1:0]        CONFIRM_NEEDED = 2'd3;
  localparam logic [CORR_W-1:0] MID_CODE       = 12'h7FF;

  localparam logic [PHASE_W-1:0] PH_CAPTURE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_CHECK   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_ACCUM   = 2'd2;
  localparam logic [PHASE_W-1:0] PH_WAIT    = 2'd3;

  typedef struct packed {
    logic capture;
    logic prep;
    logic diff;
    logic eval;
    logic div_step;
    logic finish;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
  } dp_status_t;

endpackage
`default_nettype wire

### design/cgzo_if.sv
`default_nettype none
interface cgzo_in_if;
  import cgzo_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [TIME_W-1:0]    now_ms;
  logic [FIELD_W-1:0]   current_angle;
  logic [FIELD_W-1:0]   required_angle;
  logic [CODE_IN_W-1:0] rate_code;

  modport source (output valid, command, now_ms, current_angle, required_angle, rate_code,
                  input ready);
  modport sink (input valid, command, now_ms, current_angle, required_angle, rate_code,
                output ready);
endinterface

interface cgzo_out_if;
  import cgzo_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     done_res;
  logic signed [CORR_W-1:0] correction;
  logic [PHASE_W-1:0]       phase;

  modport source (output valid, done_res, correction, phase, input ready);
  modport sink (input valid, done_res, correction, phase, output ready);
endinterface
`default_nettype wire

### design/cgzo_ctrl.sv
`default_nettype none
module cgzo_ctrl #(
  parameter int unsigned ACC_W = 28
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire cgzo_pkg::dp_status_t status_i,
  output cgzo_pkg::ctrl_cmd_t    cmd_o
);
  import cgzo_pkg::*;

  localparam int unsigned DCNT_W = $clog2(ACC_W);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PREP = 7'b0000010,
    ST_DIFF = 7'b0000100,
    ST_EVAL = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_FIN  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  logic [DCNT_W-1:0]  dcnt_q, dcnt_d;
  logic               out_valid_q, out_valid_d;
  logic               load;

  assign load = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    dcnt_d  = dcnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_PREP;
      end
      ST_PREP: state_d = ST_DIFF;
      ST_DIFF: state_d = ST_EVAL;
      ST_EVAL: begin
        dcnt_d  = '0;
        state_d = status_i.need_div ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        dcnt_d = dcnt_q + DCNT_W'(1);
        if (dcnt_q == DCNT_W'(ACC_W - 1)) state_d = ST_FIN;
      end
      ST_FIN: state_d = ST_OUT;
      ST_OUT: begin
        if (load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;

  assign cmd_o.capture  = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.prep     = (state_q == ST_PREP);
  assign cmd_o.diff     = (state_q == ST_DIFF);
  assign cmd_o.eval     = (state_q == ST_EVAL);
  assign cmd_o.div_step = (state_q == ST_DIV);
  assign cmd_o.finish   = (state_q == ST_FIN);
  assign cmd_o.load     = load;

endmodule
`default_nettype wire

### design/cgzo_dpath.sv
`default_nettype none
module cgzo_dpath #(
  parameter int unsigned ANGLE_BITS = 32,
  parameter int unsigned CODE_W     = 12,
  parameter int unsigned ACC_W      = 28
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire cgzo_pkg::ctrl_cmd_t               cmd_i,
  output cgzo_pkg::dp_status_t                   status_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [cgzo_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [cgzo_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              command_i,
  input  wire logic [cgzo_pkg::TIME_W-1:0]       now_ms_i,
  input  wire logic [cgzo_pkg::FIELD_W-1:0]      current_angle_i,
  input  wire logic [cgzo_pkg::FIELD_W-1:0]      required_angle_i,
  input  wire logic [cgzo_pkg::CODE_IN_W-1:0]    rate_code_i,
  output logic                                   done_res_o,
  output logic signed [cgzo_pkg::CORR_W-1:0]     correction_o,
  output logic [cgzo_pkg::PHASE_W-1:0]           phase_o
);
  import cgzo_pkg::*;

  localparam int unsigned DIV_W = CNT_W + 1;

  // Configuration registers.
  logic [CNT_W-1:0]  cnt_cfg_q;
  logic [TIME_W-1:0] wait_cfg_q;
  logic [DEV_W-1:0]  dev_cfg_q;

  // Latched input word.
  logic                  in_cmd_q;
  logic [TIME_W-1:0]     now_q;
  logic [ANGLE_BITS-1:0] cur_q;
  logic [FIELD_W-1:0]    req_q;
  logic [CODE_W-1:0]     code_q;

  // Calibration state.
  logic [PHASE_W-1:0]    phase_q;
  logic [ANGLE_BITS-1:0] ref_q;
  logic [1:0]            confirm_q;
  logic [TIME_W-1:0]     start_q;
  logic [CNT_W-1:0]      idx_q;
  logic [ACC_W-1:0]      acc_q;
  logic [CORR_W-1:0]     corr_q;
  logic [FIELD_W-1:0]    cal_q;
  logic                  done_q;

  // Scratch and divider.
  logic [ANGLE_BITS-1:0] diff_q;
  logic [TIME_W-1:0]     elapsed_q;
  logic [DIV_W-1:0]      rem_q;
  logic [DIV_W-1:0]      dvs_q;
  logic [ACC_W-1:0]      quo_q;

  // Result register.
  logic                  out_done_q;
  logic [CORR_W-1:0]     out_corr_q;
  logic [PHASE_W-1:0]    out_phase_q;

  logic [ANGLE_BITS-1:0] angle_dist;
  logic                  angle_ok;
  logic                  settled;
  logic                  waited;
  logic [ACC_W-1:0]      acc_sum;
  logic [CNT_W-1:0]      idx_inc;
  logic [CNT_W-1:0]      target;
  logic                  last_sample;
  logic [DIV_W-1:0]      divisor;
  logic [1:0]            confirm_inc;
  logic [DIV_W:0]        rem_sh;
  logic                  rem_ge;

  // The magnitude of the wrapped difference is at most half a circle, which still
  // fits in ANGLE_BITS when read as unsigned.
  assign angle_dist = diff_q[ANGLE_BITS-1] ? (~diff_q + ANGLE_BITS'(1)) : diff_q;
  assign angle_ok   = TIME_W'(angle_dist) <= {1'b0, dev_cfg_q};
  assign settled    = elapsed_q >= SETTLE_TIME;
  assign waited     = elapsed_q >= wait_cfg_q;

  assign acc_sum     = acc_q + ACC_W'(code_q);
  assign idx_inc     = idx_q + CNT_W'(1);
  assign target      = (cnt_cfg_q == '0) ? CNT_W'(1) : cnt_cfg_q;
  assign last_sample = (idx_inc == '0) || (idx_inc >= target);
  assign divisor     = (idx_inc == '0) ? {1'b1, CNT_W'(0)} : {1'b0, idx_inc};
  assign confirm_inc = confirm_q + 2'd1;

  assign status_o.need_div = (phase_q == PH_ACCUM) && angle_ok && last_sample;

  assign rem_sh = {rem_q, quo_q[ACC_W-1]};
  assign rem_ge = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_cfg_q  <= SAMPLE_COUNT_RST;
      wait_cfg_q <= WAIT_INTERVAL_RST;
      dev_cfg_q  <= MAX_DEVIATION_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SAMPLE_COUNT:  cnt_cfg_q  <= cfg_data_i[CNT_W-1:0];
        CFG_WAIT_INTERVAL: wait_cfg_q <= cfg_data_i[TIME_W-1:0];
        CFG_MAX_DEVIATION: dev_cfg_q  <= cfg_data_i[DEV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_cmd_q <= command_i;
      now_q    <= now_ms_i;
      cur_q    <= current_angle_i[ANGLE_BITS-1:0];
      req_q    <= required_angle_i;
      code_q   <= rate_code_i[CODE_W-1:0];
    end
    if (cmd_i.diff) begin
      diff_q    <= cur_q - ref_q;
      elapsed_q <= now_q - start_q;
    end
    if (cmd_i.eval) begin
      quo_q <= acc_sum;
      rem_q <= '0;
      dvs_q <= divisor;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? DIV_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DIV_W-1:0];
      quo_q <= {quo_q[ACC_W-2:0], rem_ge};
    end
    if (cmd_i.load) begin
      out_done_q  <= done_q;
      out_corr_q  <= corr_q;
      out_phase_q <= phase_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_CAPTURE;
      ref_q     <= '0;
      confirm_q <= '0;
      start_q   <= '0;
      idx_q     <= '0;
      acc_q     <= '0;
      corr_q    <= '0;
      cal_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      if (cmd_i.prep) begin
        if (in_cmd_q) begin
          phase_q <= PH_WAIT;
          start_q <= now_q;
          idx_q   <= '0;
          acc_q   <= '0;
        end
        // An angle change overrides the restart phase.
        if (cal_q != req_q) begin
          cal_q   <= req_q;
          phase_q <= PH_CAPTURE;
        end
      end
      if (cmd_i.eval) begin
        done_q <= 1'b0;
        case (phase_q)
          PH_CAPTURE: begin
            ref_q     <= cur_q;
            confirm_q <= '0;
            start_q   <= now_q;
            phase_q   <= PH_CHECK;
          end
          PH_CHECK: begin
            if (settled) begin
              if (angle_ok) begin
                start_q   <= now_q;
                confirm_q <= confirm_inc;
                if (confirm_inc == CONFIRM_NEEDED) begin
                  idx_q   <= '0;
                  acc_q   <= '0;
                  phase_q <= PH_ACCUM;
                end
              end else begin
                phase_q <= PH_CAPTURE;
              end
            end
          end
          PH_ACCUM: begin
            if (!angle_ok) begin
              phase_q <= PH_CAPTURE;
            end else begin
              acc_q <= acc_sum;
              idx_q <= idx_inc;
              if (last_sample) begin
                done_q  <= 1'b1;
                phase_q <= PH_WAIT;
                start_q <= now_q;
              end
            end
          end
          default: begin
            if (waited) phase_q <= PH_CAPTURE;
          end
        endcase
      end
      if (cmd_i.finish) begin
        corr_q <= MID_CODE - quo_q[CORR_W-1:0];
      end
    end
  end

  assign done_res_o   = out_done_q;
  assign correction_o = $signed(out_corr_q);
  assign phase_o      = out_phase_q;

endmodule
`default_nettype wire

### design/caged_gyro_zero_offset_calibrator_unit.sv
// Channel  Dir  Word contents
// in_i     in   command, now_ms, current_angle, required_angle, rate_code
// out_o    out  done_res, correction, phase (one word per input word)
// cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// An input word holds the block from its accept cycle through PREP, DIFF, EVAL and OUT;
// a word that completes a calibration also passes through DIV, where the restoring
// divider retires one quotient bit per cycle, and then FIN.
// Reset is asynchronous and active low; it loads the default register values.
// A result waits in an output register, so the next word is accepted while out_o stalls;
// a second result then waits until the first is taken.
`default_nettype none
`include "caged_gyro_zero_offset_calibrator_unit_defines.svh"
module caged_gyro_zero_offset_calibrator_unit #(
  parameter int unsigned ANGLE_BITS  = 32,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cgzo_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [cgzo_pkg::CFG_DATA_W-1:0] cfg_data_i,
  cgzo_in_if.sink                              in_i,
  cgzo_out_if.source                           out_o
);
  import cgzo_pkg::*;

  localparam int unsigned CODE_W = (SAMPLE_BITS < CODE_IN_W) ? SAMPLE_BITS : CODE_IN_W;
  localparam int unsigned ACC_W  = CODE_W + CNT_W;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;
  logic       out_valid;

  cgzo_ctrl #(
    .ACC_W (ACC_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cgzo_dpath #(
    .ANGLE_BITS (ANGLE_BITS),
    .CODE_W     (CODE_W),
    .ACC_W      (ACC_W)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .command_i        (in_i.command),
    .now_ms_i         (in_i.now_ms),
    .current_angle_i  (in_i.current_angle),
    .required_angle_i (in_i.required_angle),
    .rate_code_i      (in_i.rate_code),
    .done_res_o       (out_o.done_res),
    .correction_o     (out_o.correction),
    .phase_o          (out_o.phase)
  );

  assign in_i.ready = in_ready;
  assign out_o.valid = out_valid;

  `CGZO_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_ready, !in_ready)
  `CGZO_ASSERT_NEXT(a_div_holds_input, clk_i, rst_ni, cmd.div_step, !in_ready)
  `CGZO_ASSERT_NEXT(a_load_sets_valid, clk_i, rst_ni, cmd.load, out_valid)
  `CGZO_ASSERT_SAME(a_load_not_idle, clk_i, rst_ni, cmd.load, !in_ready)

endmodule
`default_nettype wire
